// ===== hdl/cfta_pkg.sv =====
// ----------------------------------------------------------------------------
// cfta_pkg
// Shared types, character codes and the hex digit function of the CAN frame
// to ASCII line encoder.
// ----------------------------------------------------------------------------
package cfta_pkg;

   localparam int IDX_W          = 5;
   localparam int MAX_DATA_BYTES = 8;

   localparam logic [7:0] CHAR_STD_DATA   = 8'h74; // t
   localparam logic [7:0] CHAR_EXT_DATA   = 8'h54; // T
   localparam logic [7:0] CHAR_STD_REMOTE = 8'h72; // r
   localparam logic [7:0] CHAR_EXT_REMOTE = 8'h52; // R
   localparam logic [7:0] CHAR_CR         = 8'h0D;
   localparam logic [7:0] CHAR_ZERO       = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A    = 8'h41;

   typedef struct packed {
      logic        is_remote;
      logic        is_extended;
      logic [28:0] frame_ident;
      logic [3:0]  byte_count;
      logic [63:0] payload;
      logic [15:0] stamp;
   } frame_type;

   typedef struct packed {
      frame_type            frame;
      logic [IDX_W-1:0]     index;
   } seq_view_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_char;
   } char_type;

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      logic [7:0] c;
      if (n < 4'd10) begin
         c = CHAR_ZERO + {4'd0, n};
      end else begin
         c = CHAR_UPPER_A + {4'd0, n - 4'd10};
      end
      return c;
   endfunction

endpackage

// ===== hdl/cfta_ifs.sv =====
// ----------------------------------------------------------------------------
// cfta interfaces
// Valid/ready channels for received frames and for line characters.
// ----------------------------------------------------------------------------
interface cfta_req_if;
   logic        valid;
   logic        ready;
   logic        is_remote;
   logic        is_extended;
   logic [28:0] frame_ident;
   logic [3:0]  byte_count;
   logic [63:0] payload;
   logic [15:0] stamp;

   modport source (output valid, is_remote, is_extended, frame_ident, byte_count,
                   payload, stamp, input ready);
   modport sink (input valid, is_remote, is_extended, frame_ident, byte_count,
                 payload, stamp, output ready);
endinterface

interface cfta_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last_char;

   modport source (output valid, out_char, last_char, input ready);
   modport sink (input valid, out_char, last_char, output ready);
endinterface

// ===== hdl/cfta_sequencer.sv =====
// ----------------------------------------------------------------------------
// cfta_sequencer
// Frame register and character index counter; takes a frame when idle or as
// the current one hands its closing character to the output register.
// ----------------------------------------------------------------------------
module cfta_sequencer
   import cfta_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   cfta_req_if.sink      req_if,
   input  logic          advance,
   input  logic          char_last,
   output logic          frame_valid,
   output seq_view_type  view
);

   frame_type         frame_ff, frame_in;
   logic              valid_ff, valid_in;
   logic [IDX_W-1:0]  index_ff, index_in;
   logic              done;
   logic              take;

   assign done         = advance && char_last;
   assign req_if.ready = !valid_ff || done;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      frame_in = frame_ff;
      valid_in = valid_ff;
      index_in = index_ff;
      if (take) begin
         frame_in.is_remote   = req_if.is_remote;
         frame_in.is_extended = req_if.is_extended;
         frame_in.frame_ident = req_if.frame_ident;
         frame_in.byte_count  = req_if.byte_count;
         frame_in.payload     = req_if.payload;
         frame_in.stamp       = req_if.stamp;
         valid_in             = 1'b1;
         index_in             = '0;
      end else if (done) begin
         valid_in = 1'b0;
         index_in = '0;
      end else if (advance) begin
         index_in = index_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         index_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         index_ff <= index_in;
      end
      frame_ff <= frame_in;
   end

   assign frame_valid = valid_ff;
   assign view.frame  = frame_ff;
   assign view.index  = index_ff;

endmodule

// ===== hdl/cfta_char_gen.sv =====
// ----------------------------------------------------------------------------
// cfta_char_gen
// Picks the character at one position of the encoded line.
// ----------------------------------------------------------------------------
module cfta_char_gen
   import cfta_pkg::*;
(
   input  seq_view_type view,
   input  logic         ts_enable,
   output char_type     char_out
);

   logic [IDX_W-1:0] id_digits;
   logic [IDX_W-1:0] len_pos;
   logic [IDX_W-1:0] data_start;
   logic [IDX_W-1:0] data_digits;
   logic [IDX_W-1:0] ts_start;
   logic [IDX_W-1:0] cr_pos;
   logic [IDX_W-1:0] id_off;
   logic [IDX_W-1:0] data_off;
   logic [IDX_W-1:0] ts_off;
   logic [3:0]       nbytes;
   logic [31:0]      ident32;
   logic [2:0]       id_nib;
   logic [3:0]       data_nib;
   logic [1:0]       ts_nib;
   logic [7:0]       letter;
   logic [3:0]       nibble;
   frame_type        f;

   assign f       = view.frame;
   assign ident32 = {3'd0, f.frame_ident};
   assign nbytes  = (f.byte_count > 4'(MAX_DATA_BYTES)) ? 4'(MAX_DATA_BYTES) : f.byte_count;

   assign id_digits   = f.is_extended ? IDX_W'(8) : IDX_W'(3);
   assign len_pos     = id_digits + IDX_W'(1);
   assign data_start  = len_pos + IDX_W'(1);
   assign data_digits = f.is_remote ? '0 : {nbytes, 1'b0};
   assign ts_start    = data_start + data_digits;
   assign cr_pos      = ts_start + (ts_enable ? IDX_W'(4) : IDX_W'(0));

   assign id_off   = view.index - IDX_W'(1);
   assign data_off = view.index - data_start;
   assign ts_off   = view.index - ts_start;

   // most significant digit first; standard ids print the low three nibbles
   assign id_nib   = f.is_extended ? (3'd7 - id_off[2:0]) : (3'd2 - id_off[2:0]);
   // each byte goes high nibble then low nibble
   assign data_nib = {data_off[3:1], ~data_off[0]};
   assign ts_nib   = 2'd3 - ts_off[1:0];

   always_comb begin
      case ({f.is_remote, f.is_extended})
         2'b00:   letter = CHAR_STD_DATA;
         2'b01:   letter = CHAR_EXT_DATA;
         2'b10:   letter = CHAR_STD_REMOTE;
         2'b11:   letter = CHAR_EXT_REMOTE;
         default: letter = CHAR_STD_DATA;
      endcase
   end

   always_comb begin
      nibble             = '0;
      char_out.last_char = 1'b0;
      if (view.index == '0) begin
         char_out.out_char = letter;
      end else if (view.index < len_pos) begin
         nibble            = ident32[{id_nib, 2'b00} +: 4];
         char_out.out_char = hex_char(nibble);
      end else if (view.index == len_pos) begin
         char_out.out_char = hex_char(f.byte_count);
      end else if (view.index < ts_start) begin
         nibble            = f.payload[{data_nib, 2'b00} +: 4];
         char_out.out_char = hex_char(nibble);
      end else if (view.index < cr_pos) begin
         nibble            = f.stamp[{ts_nib, 2'b00} +: 4];
         char_out.out_char = hex_char(nibble);
      end else begin
         char_out.out_char  = CHAR_CR;
         char_out.last_char = 1'b1;
      end
   end

endmodule

// ===== hdl/can_frame_to_ascii_serializer.sv =====
// ----------------------------------------------------------------------------
// can_frame_to_ascii_serializer
// Encodes one received CAN frame as its serial-line ASCII text, one
// character per output item, closing carriage return flagged as last.
//
//   channel | dir | payload                                         | item
//   req_if  | in  | is_remote is_extended frame_ident byte_count    | frame
//           |     | payload stamp                                   |
//   rsp_if  | out | out_char last_char                              | char
//   csr     | in  | csr_write_data = timestamp enable               | write
//
// One character leaves per cycle unless rsp stalls; a frame is its letter,
// 3 or 8 id digits, length digit, 2 per data byte (none if remote), 4 stamp
// digits if enabled and CR, walked by the character index counter.
// The next frame is taken in the cycle the current CR enters the output
// register, so frames follow with no gap. rsp ready low holds the output
// register and the counter. Synchronous reset clears the valids and the
// timestamp enable.
// ----------------------------------------------------------------------------
module can_frame_to_ascii_serializer
   import cfta_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   cfta_req_if.sink    req_if,
   cfta_rsp_if.source  rsp_if,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   seq_view_type view;
   char_type     gen_char;
   logic         frame_valid;
   logic         advance;
   logic         ts_en_ff, ts_en_in;
   logic         out_valid_ff, out_valid_in;
   char_type     out_ff, out_in;

   assign advance = frame_valid && (!out_valid_ff || rsp_if.ready);

   cfta_sequencer u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .advance     (advance),
      .char_last   (gen_char.last_char),
      .frame_valid (frame_valid),
      .view        (view)
   );

   cfta_char_gen u_gen (
      .view      (view),
      .ts_enable (ts_en_ff),
      .char_out  (gen_char)
   );

   assign ts_en_in     = csr_write_enable ? csr_write_data : ts_en_ff;
   assign out_in       = advance ? gen_char : out_ff;
   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         ts_en_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         ts_en_ff     <= ts_en_in;
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.out_char  = out_ff.out_char;
   assign rsp_if.last_char = out_ff.last_char;

endmodule

// ===== hdl/cfta_checker.sv =====
// ----------------------------------------------------------------------------
// cfta_checker
// Port-level checks of the line encoder, bound to the top level.
// ----------------------------------------------------------------------------
module cfta_checker
   import cfta_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_char,
   input logic       rsp_last
);

   // a pending character is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // an accepted frame leads to a valid character at the output
   a_frame_out: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid)
      else $error("no character after accepted frame");

   // only the closing carriage return carries last
   a_last_cr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_char == CHAR_CR)))
      else $error("last flag and carriage return disagree");

   // reset leaves no character pending
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind can_frame_to_ascii_serializer cfta_checker u_cfta_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_char  (rsp_if.out_char),
   .rsp_last  (rsp_if.last_char)
);

// ===== test/tb_can_frame_to_ascii_serializer.sv =====
// ----------------------------------------------------------------------------
// tb_can_frame_to_ascii_serializer
// Self-checking bench for the CAN frame to ASCII line encoder. A queue-fed
// driver sends directed and random frames while a monitor predicts each text
// line and compares every character that leaves the block. The timestamp
// enable is switched between phases, and both sides stall at random in the first two.
// ----------------------------------------------------------------------------
module tb_can_frame_to_ascii_serializer;
   import cfta_pkg::*;

   typedef struct {
      frame_type frame;
      bit        wait_for_lines;
   } queued_frame_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;

   cfta_req_if req_if ();
   cfta_rsp_if rsp_if ();

   can_frame_to_ascii_serializer dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if.sink),
      .rsp_if           (rsp_if.source),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   queued_frame_type frame_queue[$];
   char_type         line_queue[$];

   logic stamp_on;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   frames_pushed;
   int   frames_sent;
   int   lines_closed;
   int   chars_checked;
   int   fail_count;
   int   remote_frames;
   int   extended_frames;
   int   long_frames;
   int   stamped_lines;

   function automatic logic [7:0] ascii_hex(input logic [3:0] nibble);
      string digits;
      digits = "0123456789ABCDEF";
      return digits.getc(int'(nibble));
   endfunction

   function automatic void add_char(input logic [7:0] ch, input logic last);
      char_type c;
      c.out_char  = ch;
      c.last_char = last;
      line_queue.push_back(c);
   endfunction

   // builds the expected text line of one frame
   function automatic void encode_line(input frame_type f);
      logic [31:0] ident32;
      logic [7:0]  data_byte;
      int          n_bytes;
      ident32 = {3'b000, f.frame_ident};
      if (f.is_remote) begin
         add_char(f.is_extended ? CHAR_EXT_REMOTE : CHAR_STD_REMOTE, 1'b0);
      end else begin
         add_char(f.is_extended ? CHAR_EXT_DATA : CHAR_STD_DATA, 1'b0);
      end
      if (f.is_extended) begin
         for (int i = 0; i < 8; i++) add_char(ascii_hex(ident32[(28 - 4 * i) +: 4]), 1'b0);
      end else begin
         // all 12 low bits, so bit 11 shows up even on a standard id
         for (int i = 0; i < 3; i++) add_char(ascii_hex(ident32[(8 - 4 * i) +: 4]), 1'b0);
      end
      add_char(ascii_hex(f.byte_count), 1'b0);
      if (!f.is_remote) begin
         n_bytes = (f.byte_count > MAX_DATA_BYTES) ? MAX_DATA_BYTES : int'(f.byte_count);
         for (int i = 0; i < n_bytes; i++) begin
            data_byte = f.payload[8 * i +: 8];
            add_char(ascii_hex(data_byte[7:4]), 1'b0);
            add_char(ascii_hex(data_byte[3:0]), 1'b0);
         end
      end
      if (stamp_on) begin
         for (int i = 0; i < 4; i++) add_char(ascii_hex(f.stamp[(12 - 4 * i) +: 4]), 1'b0);
      end
      add_char(CHAR_CR, 1'b1);
   endfunction

   function automatic frame_type make_frame(input logic remote, input logic ext,
                                            input logic [28:0] ident, input logic [3:0] count,
                                            input logic [63:0] data, input logic [15:0] ts);
      frame_type f;
      f.is_remote   = remote;
      f.is_extended = ext;
      f.frame_ident = ident;
      f.byte_count  = count;
      f.payload     = data;
      f.stamp       = ts;
      return f;
   endfunction

   function automatic frame_type random_frame();
      frame_type f;
      int        pick;
      f.is_remote   = ($urandom_range(4) == 0);
      f.is_extended = 1'($urandom_range(1));
      pick = $urandom_range(9);
      if (f.is_extended || pick > 7) begin
         f.frame_ident = 29'($urandom);
      end else begin
         f.frame_ident = 29'($urandom_range(11'h7FF));
      end
      pick = $urandom_range(9);
      if (pick == 9) begin
         f.byte_count = 4'($urandom_range(15, 9));
      end else begin
         f.byte_count = 4'($urandom_range(8));
      end
      f.payload = {$urandom, $urandom};
      f.stamp   = 16'($urandom);
      return f;
   endfunction

   function automatic void queue_frame(input frame_type f, input bit hold);
      queued_frame_type q;
      q.frame          = f;
      q.wait_for_lines = hold;
      frame_queue.push_back(q);
      frames_pushed++;
   endfunction

   task automatic set_stamp_enable(input logic value);
      @(posedge clock);
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      stamp_on = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic wait_for_lines();
      while (lines_closed != frames_pushed) @(posedge clock);
   endtask

   task automatic queue_random(input int count);
      repeat (count) queue_frame(random_frame(), $urandom_range(29) == 0);
   endtask

   // driver: presents queued frames, some only once every line has come back
   always @(posedge clock) begin
      queued_frame_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) frames_sent++;
         if (!req_if.valid || req_if.ready) begin
            if (frame_queue.size() != 0
                && (!frame_queue[0].wait_for_lines || lines_closed == frames_sent)
                && $urandom_range(99) >= send_idle_pct) begin
               nxt = frame_queue.pop_front();
               req_if.is_remote   <= nxt.frame.is_remote;
               req_if.is_extended <= nxt.frame.is_extended;
               req_if.frame_ident <= nxt.frame.frame_ident;
               req_if.byte_count  <= nxt.frame.byte_count;
               req_if.payload     <= nxt.frame.payload;
               req_if.stamp       <= nxt.frame.stamp;
               req_if.valid       <= 1'b1;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: predicts on frame accept, checks each character
   always @(posedge clock) begin
      frame_type f;
      char_type  want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            f = {req_if.is_remote, req_if.is_extended, req_if.frame_ident,
                 req_if.byte_count, req_if.payload, req_if.stamp};
            encode_line(f);
            if (f.is_remote) remote_frames++;
            if (f.is_extended) extended_frames++;
            if (f.byte_count > MAX_DATA_BYTES) long_frames++;
            if (stamp_on) stamped_lines++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            chars_checked++;
            if (line_queue.size() == 0) begin
               $error("unexpected item: out_char %h last_char %b",
                      rsp_if.out_char, rsp_if.last_char);
               fail_count++;
            end else begin
               want = line_queue.pop_front();
               if (rsp_if.out_char !== want.out_char) begin
                  $error("out_char: expected %h, actual %h", want.out_char, rsp_if.out_char);
                  fail_count++;
               end
               if (rsp_if.last_char !== want.last_char) begin
                  $error("last_char: expected %b, actual %b", want.last_char, rsp_if.last_char);
                  fail_count++;
               end
               if (want.last_char) lines_closed <= lines_closed + 1;
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_write_data     = 1'b0;
      req_if.valid       = 1'b0;
      req_if.is_remote   = 1'b0;
      req_if.is_extended = 1'b0;
      req_if.frame_ident = '0;
      req_if.byte_count  = '0;
      req_if.payload     = '0;
      req_if.stamp       = '0;
      rsp_if.ready       = 1'b0;
      stamp_on           = 1'b0;
      frames_pushed      = 0;
      frames_sent        = 0;
      lines_closed       = 0;
      chars_checked      = 0;
      fail_count         = 0;
      remote_frames      = 0;
      extended_frames    = 0;
      long_frames        = 0;
      stamped_lines      = 0;
      send_idle_pct      = 18;
      recv_idle_pct      = 83;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      set_stamp_enable(1'b1);
      // field extremes, every frame type, lengths above eight
      queue_frame(make_frame(1'b0, 1'b0, 29'h0, 4'd0, 64'h0, 16'h0), 1'b0);
      queue_frame(make_frame(1'b0, 1'b0, 29'h7FF, 4'd8, '1, 16'hFFFF), 1'b0);
      queue_frame(make_frame(1'b0, 1'b0, 29'hFFF, 4'd1, 64'h5A, 16'h8001), 1'b0);
      queue_frame(make_frame(1'b0, 1'b0, 29'h1FFFF000, 4'd2, 64'hC3A5, 16'h00FF), 1'b0);
      queue_frame(make_frame(1'b0, 1'b1, 29'h1FFFFFFF, 4'd8, 64'h0123456789ABCDEF,
                             16'h1234), 1'b0);
      queue_frame(make_frame(1'b0, 1'b1, 29'h0, 4'd0, '1, 16'h0), 1'b0);
      queue_frame(make_frame(1'b0, 1'b1, 29'h10000001, 4'd8, 64'hFEDCBA9876543210,
                             16'hABCD), 1'b1);
      queue_frame(make_frame(1'b1, 1'b0, 29'h123, 4'd8, '1, 16'h5678), 1'b0);
      queue_frame(make_frame(1'b1, 1'b0, 29'h0, 4'd0, 64'h0, 16'hFFFF), 1'b0);
      queue_frame(make_frame(1'b1, 1'b1, 29'h1ABCDEF0, 4'd0, 64'h0, 16'h9ABC), 1'b0);
      queue_frame(make_frame(1'b1, 1'b1, 29'h1FFFFFFF, 4'd15, '1, 16'hFFFF), 1'b0);
      queue_frame(make_frame(1'b1, 1'b0, 29'h7FF, 4'd9, 64'h1, 16'h0), 1'b0);
      queue_frame(make_frame(1'b0, 1'b0, 29'h2AA, 4'd9, 64'h1122334455667788, 16'hDEF0),
                  1'b0);
      queue_frame(make_frame(1'b0, 1'b1, 29'h15555555, 4'd12, 64'hAA55AA55AA55AA55,
                             16'h0F0F), 1'b0);
      queue_frame(make_frame(1'b0, 1'b0, 29'h555, 4'd15, '1, 16'hF0F0), 1'b0);
      queue_frame(make_frame(1'b0, 1'b1, 29'h0ACE1234, 4'd4, 64'hFFFFFFFF00000000,
                             16'h7FFF), 1'b0);
      queue_frame(make_frame(1'b0, 1'b0, 29'h001, 4'd7, 64'h00FF00FF00FF00FF, 16'h8000),
                  1'b0);
      queue_frame(make_frame(1'b0, 1'b1, 29'h0000000F, 4'd3, 64'h0000000000BEEF42,
                             16'h0001), 1'b0);
      queue_random(46);
      wait_for_lines();

      send_idle_pct = 83;
      recv_idle_pct = 18;
      set_stamp_enable(1'b0);
      queue_frame(make_frame(1'b0, 1'b1, 29'h1FFFFFFF, 4'd8, '1, 16'hFFFF), 1'b0);
      queue_frame(make_frame(1'b1, 1'b0, 29'h7FF, 4'd15, '1, 16'hFFFF), 1'b0);
      queue_random(48);
      wait_for_lines();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_stamp_enable(1'b1);
      queue_random(46);
      wait_for_lines();

      repeat (40) @(posedge clock);
      if (line_queue.size() != 0) begin
         $error("%0d expected characters never arrived", line_queue.size());
         fail_count++;
      end
      $display("covered %0d frames (%0d remote, %0d extended, %0d with length over eight)",
               frames_sent, remote_frames, extended_frames, long_frames);
      $display("checked %0d characters, %0d lines with timestamp, %0d errors",
               chars_checked, stamped_lines, fail_count);
      if (fail_count == 0) begin
         $display("can_frame_to_ascii_serializer regression: pass");
      end else begin
         $display("can_frame_to_ascii_serializer regression: fail");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("can_frame_to_ascii_serializer regression: fail");
      $finish;
   end

endmodule

// ===== can_frame_to_ascii_serializer.f =====
hdl/cfta_pkg.sv
hdl/cfta_ifs.sv
hdl/cfta_sequencer.sv
hdl/cfta_char_gen.sv
hdl/can_frame_to_ascii_serializer.sv
hdl/cfta_checker.sv
test/tb_can_frame_to_ascii_serializer.sv
